// File: hdl/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg: escape-time fractal pixel package
// Number format, register map, reset values and the small helper functions
// shared by the interfaces, the pixel engine and its checker.
// ----------------------------------------------------------------------------
package etf_pkg;

	// Number format: signed Q(32-FRAC_BITS).FRAC_BITS in 32 bits
	localparam int FRAC_BITS  = 26;
	localparam int MAX_ITER   = 1023;
	localparam int PIXEL_BITS = 12;

	localparam int CAP_W   = 10;
	localparam int COUNT_W = 11;
	localparam int COLOR_W = 4;
	localparam int WORD_W  = 15;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W  = 31;
	localparam int BLACK_W = 10;

	// Escape when |z|^2 > 4, compared on the unshifted square sum
	localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

	localparam int COLOR_WRAP = 15;
	localparam int WORD_SCALE = 1111;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	// Configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_JULIA_RE = 3'd1,
		REG_JULIA_IM = 3'd2,
		REG_MIN_RE   = 3'd3,
		REG_MAX_IM   = 3'd4,
		REG_STEP_RE  = 3'd5,
		REG_STEP_IM  = 3'd6,
		REG_BLACK    = 3'd7
	} cfg_reg_t;

	// Reset values
	localparam logic                    RST_MODE     = 1'b0;
	localparam logic signed [CFG_W-1:0] RST_JULIA_RE = -32'sd49660559;
	localparam logic signed [CFG_W-1:0] RST_JULIA_IM = 32'sd6710886;
	localparam logic signed [CFG_W-1:0] RST_MIN_RE   = -32'sd134217728;
	localparam logic signed [CFG_W-1:0] RST_MAX_IM   = 32'sd67108864;
	localparam logic [STEP_W-1:0]       RST_STEP_RE  = 31'd419430;
	localparam logic [STEP_W-1:0]       RST_STEP_IM  = 31'd279620;
	localparam logic [BLACK_W-1:0]      RST_BLACK    = 10'd300;

	// Clamp a 64-bit signed value into the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[31:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Palette index before the black test: counts above the wrap value fold
	// modulo 15, using the nibble digit sum (16 is 1 mod 15).
	function automatic logic [COLOR_W-1:0] color_of(input logic [COUNT_W-1:0] k);
		logic [5:0] s;
		logic [5:0] r;
		s = 6'(k[3:0]) + 6'(k[7:4]) + 6'(k[10:8]);
		if (s >= 6'(2 * COLOR_WRAP)) begin
			r = s - 6'(2 * COLOR_WRAP);
		end else if (s >= 6'(COLOR_WRAP)) begin
			r = s - 6'(COLOR_WRAP);
		end else begin
			r = s;
		end
		if (k > COUNT_W'(COLOR_WRAP)) begin
			return r[COLOR_W-1:0];
		end
		return k[COLOR_W-1:0];
	endfunction

endpackage

// File: hdl/etf_if.sv
// ----------------------------------------------------------------------------
// etf_if: pixel request and pixel result channels
// Valid/ready channels; one item moves per transfer.
// ----------------------------------------------------------------------------
interface etf_in_if #(
	parameter int PIXEL_BITS = etf_pkg::PIXEL_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic [PIXEL_BITS-1:0]        pixel_x;
	logic [PIXEL_BITS-1:0]        pixel_y;
	logic [etf_pkg::CAP_W-1:0]    iteration_cap;

	modport source (output valid, output pixel_x, output pixel_y, output iteration_cap,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input iteration_cap,
		output ready);
endinterface

interface etf_out_if #(
	parameter int PIXEL_BITS = etf_pkg::PIXEL_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic [PIXEL_BITS-1:0]        out_x;
	logic [PIXEL_BITS-1:0]        out_y;
	logic [etf_pkg::COUNT_W-1:0]  escape_count;
	logic [etf_pkg::COLOR_W-1:0]  color_index;
	logic [etf_pkg::WORD_W-1:0]   pixel_word;

	modport source (output valid, output out_x, output out_y, output escape_count,
		output color_index, output pixel_word, input ready);
	modport sink (input valid, input out_x, input out_y, input escape_count,
		input color_index, input pixel_word, output ready);
endinterface

// File: hdl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel: Mandelbrot / Julia escape-time pixel engine
// Maps a pixel to the complex plane, iterates z = z^2 + c in signed fixed
// point on one shared 32x32 multiplier and reports the escape count and color.
// ----------------------------------------------------------------------------
// Throughput: one pixel at a time; a new pixel is taken only after the last result
//   is loaded into the output register. The single shared multiplier takes
//   three products per iteration and a fourth step folds them into the new z.
// Reset: arst_n clears the sequencer and output valid and loads the
//   configuration registers with their defaults.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
	parameter int PIXEL_BITS = etf_pkg::PIXEL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [etf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [etf_pkg::CFG_W-1:0]      cfg_data,
	etf_in_if.sink                         pix_in,
	etf_out_if.source                      pix_out
);

	// Sequencer: three mapping steps, then four steps per iteration
	typedef enum logic [3:0] {
		S_IDLE,
		S_MAP_RE,   // multiply pixel_x by step_re
		S_MAP_IM,   // place real coordinate, multiply pixel_y by step_im
		S_MAP_END,  // place imaginary coordinate
		S_SQ_X,     // multiply zr*zr
		S_SQ_Y,     // hold xx, multiply zi*zi
		S_CROSS,    // hold yy, escape test, multiply zr*zi
		S_UPDATE,   // form the new z from xx, yy, xy
		S_FINISH    // color and load the output register
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                                mode_q;
	logic signed [etf_pkg::CFG_W-1:0]    julia_re_q;
	logic signed [etf_pkg::CFG_W-1:0]    julia_im_q;
	logic signed [etf_pkg::CFG_W-1:0]    min_re_q;
	logic signed [etf_pkg::CFG_W-1:0]    max_im_q;
	logic [etf_pkg::STEP_W-1:0]          step_re_q;
	logic [etf_pkg::STEP_W-1:0]          step_im_q;
	logic [etf_pkg::BLACK_W-1:0]         black_q;

	// Working registers
	logic [PIXEL_BITS-1:0]               px_q;
	logic [PIXEL_BITS-1:0]               py_q;
	logic [etf_pkg::CAP_W-1:0]           cap_q;
	logic [etf_pkg::CAP_W-1:0]           k_q;
	logic                                first_q;
	logic [etf_pkg::COUNT_W-1:0]         count_q;
	logic signed [31:0]                  zr_q;
	logic signed [31:0]                  zi_q;
	logic signed [31:0]                  cr_q;
	logic signed [31:0]                  ci_q;
	logic signed [63:0]                  prod_q;
	logic signed [63:0]                  xx_q;
	logic signed [63:0]                  yy_q;

	// Output register
	logic                                out_valid_q;
	logic [PIXEL_BITS-1:0]               out_x_q;
	logic [PIXEL_BITS-1:0]               out_y_q;
	logic [etf_pkg::COUNT_W-1:0]         out_count_q;
	logic [etf_pkg::COLOR_W-1:0]         out_color_q;
	logic [etf_pkg::WORD_W-1:0]          out_word_q;

	// Shared multiplier and the logic around it
	logic signed [31:0]                  mul_a;
	logic signed [31:0]                  mul_b;
	logic signed [63:0]                  mul_p;
	logic signed [63:0]                  map_re_sum;
	logic signed [63:0]                  map_im_sum;
	logic signed [31:0]                  pre_sat;
	logic signed [31:0]                  pim_sat;
	logic signed [63:0]                  re_diff;
	logic signed [63:0]                  re_sh;
	logic signed [63:0]                  im_sh;
	logic signed [31:0]                  nr_sat;
	logic signed [31:0]                  ni_sat;
	logic [63:0]                         mag;
	logic                                esc;
	logic                                in_xfer;
	logic                                out_load;
	logic [etf_pkg::COLOR_W-1:0]         color_mod;
	logic [etf_pkg::COLOR_W-1:0]         color;

	assign in_xfer  = pix_in.valid && pix_in.ready;
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || pix_out.ready);

	// Pick the multiplier operands for this step
	always_comb begin
		case (state_q)
			S_MAP_RE: begin
				mul_a = 32'(px_q);
				mul_b = 32'(step_re_q);
			end
			S_MAP_IM: begin
				mul_a = 32'(py_q);
				mul_b = 32'(step_im_q);
			end
			S_SQ_X: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			S_SQ_Y: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			S_CROSS: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Plane mapping: column moves right from min_re, row moves down from max_im
	assign map_re_sum = 64'(min_re_q) + prod_q;
	assign map_im_sum = 64'(max_im_q) - prod_q;
	assign pre_sat    = etf_pkg::sat32(map_re_sum);
	assign pim_sat    = etf_pkg::sat32(map_im_sum);

	// z^2 + c: the arithmetic shifts round toward minus infinity; the cross
	// term shifts one less to take the factor of two
	assign re_diff = xx_q - yy_q;
	assign re_sh   = re_diff >>> etf_pkg::FRAC_BITS;
	assign im_sh   = prod_q >>> (etf_pkg::FRAC_BITS - 1);
	assign nr_sat  = etf_pkg::sat32(re_sh + 64'(cr_q));
	assign ni_sat  = etf_pkg::sat32(im_sh + 64'(ci_q));

	// |z|^2 of the current z; the squares double as the next iteration's
	assign mag = 64'(xx_q) + 64'(prod_q);
	assign esc = mag > etf_pkg::ESC_LIMIT;

	// Counts at or above the black limit drop to palette index 0
	assign color_mod = etf_pkg::color_of(count_q);
	assign color     = (count_q >= etf_pkg::COUNT_W'(black_q)) ? '0 : color_mod;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= etf_pkg::RST_MODE;
			julia_re_q <= etf_pkg::RST_JULIA_RE;
			julia_im_q <= etf_pkg::RST_JULIA_IM;
			min_re_q   <= etf_pkg::RST_MIN_RE;
			max_im_q   <= etf_pkg::RST_MAX_IM;
			step_re_q  <= etf_pkg::RST_STEP_RE;
			step_im_q  <= etf_pkg::RST_STEP_IM;
			black_q    <= etf_pkg::RST_BLACK;
		end else if (cfg_we) begin
			case (etf_pkg::cfg_reg_t'(cfg_index))
				etf_pkg::REG_MODE:     mode_q     <= cfg_data[0];
				etf_pkg::REG_JULIA_RE: julia_re_q <= cfg_data;
				etf_pkg::REG_JULIA_IM: julia_im_q <= cfg_data;
				etf_pkg::REG_MIN_RE:   min_re_q   <= cfg_data;
				etf_pkg::REG_MAX_IM:   max_im_q   <= cfg_data;
				etf_pkg::REG_STEP_RE:  step_re_q  <= cfg_data[etf_pkg::STEP_W-1:0];
				etf_pkg::REG_STEP_IM:  step_im_q  <= cfg_data[etf_pkg::STEP_W-1:0];
				etf_pkg::REG_BLACK:    black_q    <= cfg_data[etf_pkg::BLACK_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state, iteration counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_MAP_RE;
					end
				end
				S_MAP_RE:  state_q <= S_MAP_IM;
				S_MAP_IM:  state_q <= S_MAP_END;
				S_MAP_END: begin
					k_q     <= '0;
					first_q <= 1'b1;
					state_q <= S_SQ_X;
				end
				S_SQ_X:    state_q <= S_SQ_Y;
				S_SQ_Y:    state_q <= S_CROSS;
				S_CROSS: begin
					// The start point is never tested; after that, stop on
					// escape or once the last allowed iteration is done
					if (first_q) begin
						first_q <= 1'b0;
						state_q <= S_UPDATE;
					end else if (esc || (k_q == cap_q)) begin
						state_q <= S_FINISH;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE:  state_q <= S_SQ_X;
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					px_q <= pix_in.pixel_x;
					py_q <= pix_in.pixel_y;
					if (int'(pix_in.iteration_cap) > etf_pkg::MAX_ITER) begin
						cap_q <= etf_pkg::CAP_W'(etf_pkg::MAX_ITER);
					end else begin
						cap_q <= pix_in.iteration_cap;
					end
				end
			end
			S_MAP_IM: begin
				// Julia starts z at the point; Mandelbrot uses it as c
				if (mode_q) begin
					zr_q <= pre_sat;
					cr_q <= julia_re_q;
				end else begin
					zr_q <= '0;
					cr_q <= pre_sat;
				end
			end
			S_MAP_END: begin
				if (mode_q) begin
					zi_q <= pim_sat;
					ci_q <= julia_im_q;
				end else begin
					zi_q <= '0;
					ci_q <= pim_sat;
				end
			end
			S_SQ_Y: xx_q <= prod_q;
			S_CROSS: begin
				yy_q <= prod_q;
				if (esc) begin
					count_q <= etf_pkg::COUNT_W'(k_q);
				end else begin
					count_q <= etf_pkg::COUNT_W'(cap_q) + 1'b1;
				end
			end
			S_UPDATE: begin
				zr_q <= nr_sat;
				zi_q <= ni_sat;
			end
			S_FINISH: begin
				if (out_load) begin
					out_x_q     <= px_q;
					out_y_q     <= py_q;
					out_count_q <= count_q;
					out_color_q <= color;
					out_word_q  <= etf_pkg::WORD_W'(color) *
						etf_pkg::WORD_W'(etf_pkg::WORD_SCALE);
				end
			end
			default: ;
		endcase
	end

	// Accept a new pixel only while the sequencer is idle
	assign pix_in.ready = (state_q == S_IDLE);

	assign pix_out.valid        = out_valid_q;
	assign pix_out.out_x        = out_x_q;
	assign pix_out.out_y        = out_y_q;
	assign pix_out.escape_count = out_count_q;
	assign pix_out.color_index  = out_color_q;
	assign pix_out.pixel_word   = out_word_q;

endmodule

// File: hdl/etf_checker.sv
// ----------------------------------------------------------------------------
// etf_checker: port-level checks for the fractal pixel engine
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module etf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [etf_pkg::COUNT_W-1:0]   escape_count,
	input logic [etf_pkg::COLOR_W-1:0]   color_index,
	input logic [etf_pkg::WORD_W-1:0]    pixel_word
);

	// The engine goes busy right after taking a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("engine still ready after input transfer");

	// A new result shows up only at the end of a busy stretch
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while engine was idle");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(escape_count)
			&& $stable(color_index) && $stable(pixel_word)))
		else $error("stalled result changed or dropped");

	// Pixel word tracks the palette index
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_word == etf_pkg::WORD_W'(color_index) *
			etf_pkg::WORD_W'(etf_pkg::WORD_SCALE)))
		else $error("pixel word does not match color index");

endmodule

bind escape_time_fractal_pixel etf_checker u_etf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix_in.valid),
	.in_ready     (pix_in.ready),
	.out_valid    (pix_out.valid),
	.out_ready    (pix_out.ready),
	.escape_count (pix_out.escape_count),
	.color_index  (pix_out.color_index),
	.pixel_word   (pix_out.pixel_word)
);
